// File: rtl/core/rcsfd_pkg.sv
// Shared types, constants and axis conversion for the serial frame decoder.
// No dependencies; imported by every file of the decoder.

package rcsfd_pkg;

  localparam int unsigned IBUS_CHANNEL_COUNT = 14;
  localparam int unsigned SUM_MODE_WORDS     = 7;
  localparam int unsigned NUM_WORDS_KEPT     = 7;
  localparam int unsigned POS_W              = 5;
  localparam int unsigned IDX_W              = $clog2(NUM_WORDS_KEPT);

  localparam logic [7:0] IBUS_HDR_A = 8'h20;
  localparam logic [7:0] IBUS_HDR_B = 8'h40;
  localparam logic [7:0] SUM_HDR_A  = 8'd85;
  localparam logic [7:0] SUM_HDR_B  = 8'd252;

  localparam logic [15:0] CSUM_INIT   = 16'hFFFF;
  localparam logic [15:0] IBUS_CENTRE = 16'd1500;
  localparam logic [15:0] SUM_OFFSET  = 16'd1000;
  localparam logic [15:0] SUM_CLAMP   = 16'd1022;
  localparam logic [15:0] SUM_MID     = 16'd511;

  localparam logic [1:0] STAT_GOOD     = 2'd0;
  localparam logic [1:0] STAT_TEST_BAD = 2'd1;
  localparam logic [1:0] STAT_CSUM_BAD = 2'd2;

  typedef logic [15:0] word_t;
  typedef word_t [NUM_WORDS_KEPT-1:0] chan_words_t;

  typedef struct packed {
    logic        ibus;
    logic        frame_end;
    logic        csum_ok;
    chan_words_t words;
  } parse_info_t;

  function automatic word_t sum_offset(input word_t w);
    return w - SUM_OFFSET;
  endfunction

  function automatic word_t axis_convert(input word_t w, input logic ibus);
    word_t a;
    a = sum_offset(w);
    if (ibus) begin
      a = w - IBUS_CENTRE;
    end else begin
      if (a > SUM_CLAMP) begin
        a = SUM_CLAMP;
      end
      a = a - SUM_MID;
    end
    return a;
  endfunction

endpackage

// File: rtl/core/rcsfd_parser.sv
// Header hunt, channel word gathering and running checksum, one byte a cycle.
// Depends on rcsfd_pkg.

module rcsfd_parser
  import rcsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_mode_i,
  input  logic        byte_we_i,
  input  logic [7:0]  byte_i,
  output parse_info_t info_o
);

  localparam logic [2:0] PH_HUNT_A      = 3'd0;
  localparam logic [2:0] PH_HUNT_B      = 3'd1;
  localparam logic [2:0] PH_WORD_FIRST  = 3'd2;
  localparam logic [2:0] PH_WORD_SECOND = 3'd3;
  localparam logic [2:0] PH_CHECK_FIRST = 3'd4;
  localparam logic [2:0] PH_CHECK_SECOND = 3'd5;

  localparam logic [POS_W-1:0] NWORDS_IBUS = POS_W'(IBUS_CHANNEL_COUNT);
  localparam logic [POS_W-1:0] NWORDS_SUM  = POS_W'(SUM_MODE_WORDS);
  localparam logic [POS_W-1:0] NWORDS_KEPT = POS_W'(NUM_WORDS_KEPT);

  logic             mode_q, mode_d;
  logic [2:0]       phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  word_t            csum_q, csum_d;
  logic [7:0]       pend_q, pend_d;
  chan_words_t      words_q;

  logic             ibus;
  logic [POS_W-1:0] nwords;
  word_t            joined;
  word_t            csum_in;
  logic             word_we;

  assign ibus    = mode_q;
  assign nwords  = ibus ? NWORDS_IBUS : NWORDS_SUM;
  assign joined  = ibus ? {byte_i, pend_q} : {pend_q, byte_i};
  assign csum_in = ibus ? (csum_q - {8'd0, byte_i}) : (csum_q + {8'd0, byte_i});

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    csum_d  = csum_q;
    pend_d  = pend_q;
    word_we = 1'b0;
    if (cfg_we_i) begin
      mode_d  = cfg_mode_i;
      phase_d = PH_HUNT_A;
      pos_d   = '0;
      csum_d  = CSUM_INIT;
    end else if (byte_we_i) begin
      unique case (phase_q)
        PH_HUNT_B: begin
          if (byte_i == (ibus ? IBUS_HDR_B : SUM_HDR_B)) begin
            phase_d = PH_WORD_FIRST;
            csum_d  = ibus ? csum_in : '0;
          end else begin
            phase_d = PH_HUNT_A;
          end
          pos_d = '0;
        end
        PH_WORD_FIRST: begin
          pend_d  = byte_i;
          csum_d  = csum_in;
          phase_d = PH_WORD_SECOND;
        end
        PH_WORD_SECOND: begin
          word_we = (pos_q < NWORDS_KEPT);
          csum_d  = csum_in;
          pos_d   = pos_q + 1'b1;
          phase_d = (pos_d >= nwords) ? PH_CHECK_FIRST : PH_WORD_FIRST;
        end
        PH_CHECK_FIRST: begin
          pend_d  = byte_i;
          phase_d = PH_CHECK_SECOND;
        end
        PH_CHECK_SECOND: begin
          phase_d = PH_HUNT_A;
          pos_d   = '0;
          csum_d  = CSUM_INIT;
        end
        default: begin
          phase_d = PH_HUNT_A;
          if (byte_i == (ibus ? IBUS_HDR_A : SUM_HDR_A)) begin
            phase_d = PH_HUNT_B;
            if (ibus) begin
              csum_d = CSUM_INIT - {8'd0, byte_i};
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= PH_HUNT_A;
      pos_q   <= '0;
      csum_q  <= CSUM_INIT;
      pend_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      csum_q  <= csum_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      words_q[pos_q[IDX_W-1:0]] <= joined;
    end
  end

  assign info_o.ibus      = ibus;
  assign info_o.frame_end = (phase_q == PH_CHECK_SECOND);
  assign info_o.csum_ok   = (joined == csum_q);
  assign info_o.words     = words_q;

endmodule

// File: rtl/core/rc_serial_frame_decoder_top.sv
// Top level of the serial frame decoder: handshakes, axis conversion, result register.
// Depends on rcsfd_pkg and rcsfd_parser.
//
//  channel | valid / ready            | payload
//  rx      | rx_valid_i / rx_ready_o  | rx_byte_i
//  cfg     | cfg_valid_i / cfg_ready_o| frame_mode_i
//  out     | out_valid_o / out_ready_i| six axes, frame_status_o
//
// One byte a cycle, save for the hold-off below; a frame's result appears the cycle after its last byte.
// Bytes that close no frame are taken even while a result waits; only the
// last checksum byte holds off behind an untaken result register.
// Reset clears the hunt state and selects the sum-checked frame format.

module rc_serial_frame_decoder_top
  import rcsfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               frame_mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_x_o,
  output logic signed [15:0] left_y_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] aux_one_o,
  output logic signed [15:0] aux_two_o,
  output logic [1:0]         frame_status_o
);

  parse_info_t info;
  logic        rx_acc;
  logic        cfg_acc;
  logic        load;
  logic        out_valid_q, out_valid_d;
  word_t       ax [6];
  word_t       axes_d [6];
  word_t       axes_q [6];
  logic [1:0]  stat_d, stat_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign rx_ready_o  = !out_valid_q || out_ready_i || !info.frame_end;
  assign rx_acc      = rx_valid_i && rx_ready_o;
  assign load        = rx_acc && !cfg_acc && info.frame_end;

  rcsfd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_acc),
    .cfg_mode_i (frame_mode_i),
    .byte_we_i  (rx_acc),
    .byte_i     (rx_byte_i),
    .info_o     (info)
  );

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ax[i] = axis_convert(info.words[i], info.ibus);
    end
    stat_d = STAT_GOOD;
    if (!info.csum_ok) begin
      stat_d = STAT_CSUM_BAD;
    end else if (!info.ibus && (info.words[6] != sum_offset(info.words[2]))) begin
      stat_d = STAT_TEST_BAD;
    end
    axes_d[0] = ax[3];
    axes_d[1] = ax[2];
    axes_d[2] = ax[0];
    axes_d[3] = ax[1];
    axes_d[4] = ax[4];
    axes_d[5] = ax[5];
    if (!info.csum_ok) begin
      for (int i = 0; i < 6; i++) begin
        axes_d[i] = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      axes_q <= axes_d;
      stat_q <= stat_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_x_o       = axes_q[0];
  assign left_y_o       = axes_q[1];
  assign right_x_o      = axes_q[2];
  assign right_y_o      = axes_q[3];
  assign aux_one_o      = axes_q[4];
  assign aux_two_o      = axes_q[5];
  assign frame_status_o = stat_q;

endmodule

// File: rtl/core/rcsfd_checker.sv
// Port-level checks for the serial frame decoder, bound to the top level.
// Depends on rcsfd_pkg and rc_serial_frame_decoder_top.

module rcsfd_checker
  import rcsfd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rx_valid_i,
  input logic               rx_ready_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] left_x_o,
  input logic signed [15:0] left_y_o,
  input logic signed [15:0] right_x_o,
  input logic signed [15:0] right_y_o,
  input logic signed [15:0] aux_one_o,
  input logic signed [15:0] aux_two_o,
  input logic [1:0]         frame_status_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_status_o))
    else $error("result word dropped or changed while stalled");

  a_new_word_from_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rx_valid_i && rx_ready_o))
    else $error("result word without an accepted byte");

  a_bad_csum_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == STAT_CSUM_BAD |->
      left_x_o == 16'sd0 && left_y_o == 16'sd0 && right_x_o == 16'sd0 &&
      right_y_o == 16'sd0 && aux_one_o == 16'sd0 && aux_two_o == 16'sd0)
    else $error("bad checksum word carries axis data");

  a_cfg_always_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration word held off");

endmodule

bind rc_serial_frame_decoder_top rcsfd_checker u_rcsfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rx_valid_i     (rx_valid_i),
  .rx_ready_o     (rx_ready_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .left_x_o       (left_x_o),
  .left_y_o       (left_y_o),
  .right_x_o      (right_x_o),
  .right_y_o      (right_y_o),
  .aux_one_o      (aux_one_o),
  .aux_two_o      (aux_two_o),
  .frame_status_o (frame_status_o)
);
